FILE: hw/rtl/yqrgb_pkg.sv
// yqrgb_pkg: widths, chroma term tables and clamp helper for the yuv420 block converter
// no dependencies; imported by yuv420_quad_to_rgb
package yqrgb_pkg;

  localparam int SAMPLE_W  = 8;
  localparam int TERM_W    = 9;   // widest term is -227 .. 225
  localparam int SUM_W     = 11;  // y + gv + gu spans -134 .. 390
  localparam int NUM_PIX   = 4;
  localparam int NUM_IN    = 6;
  localparam int NUM_CHAN  = 3;
  localparam int TABLE_N   = 256;
  localparam int CHROMA_OFS = 128;
  localparam int IN_DATA_W  = NUM_IN * SAMPLE_W;
  localparam int OUT_DATA_W = NUM_PIX * NUM_CHAN * SAMPLE_W;

  // coefficients as exact decimal ratios
  localparam int RV_NUM = 14075;
  localparam int RV_DEN = 10000;
  localparam int GV_NUM = -7169;
  localparam int GV_DEN = 10000;
  localparam int GU_NUM = -691;
  localparam int GU_DEN = 2000;
  localparam int BU_NUM = 1779;
  localparam int BU_DEN = 1000;

  localparam logic [SAMPLE_W-1:0] PIX_MAX = 8'hFF;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef term_t [TABLE_N-1:0] term_table_t;

  typedef enum logic [1:0] {
    TERM_RV = 2'd0,
    TERM_GV = 2'd1,
    TERM_GU = 2'd2,
    TERM_BU = 2'd3
  } term_sel_t;

  // build one term table, indexed by the raw chroma byte; division truncates toward zero
  function automatic term_table_t build_table(input term_sel_t sel);
    term_table_t t;
    int d;
    for (int i = 0; i < TABLE_N; i++) begin
      d = i - CHROMA_OFS;
      case (sel)
        TERM_RV: t[i] = TERM_W'((RV_NUM * d) / RV_DEN);
        TERM_GV: t[i] = TERM_W'((GV_NUM * d) / GV_DEN);
        TERM_GU: t[i] = TERM_W'((GU_NUM * d) / GU_DEN);
        default: t[i] = TERM_W'((BU_NUM * d) / BU_DEN);
      endcase
    end
    return t;
  endfunction

  localparam term_table_t RV_TABLE = build_table(TERM_RV);
  localparam term_table_t GV_TABLE = build_table(TERM_GV);
  localparam term_table_t GU_TABLE = build_table(TERM_GU);
  localparam term_table_t BU_TABLE = build_table(TERM_BU);

  // saturate a signed sum to 0..255
  function automatic sample_t clamp8(input sum_t x);
    sample_t r;
    if (x < 0) begin
      r = '0;
    end else if (x > sum_t'(PIX_MAX)) begin
      r = PIX_MAX;
    end else begin
      r = x[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/yuv420_quad_to_rgb.sv
// yuv420_quad_to_rgb: converts one 2x2 block of 4:2:0 samples to rgb for its four pixels
// depends on yqrgb_pkg for term tables, widths and the clamp function
//
// usage:
//   in_* is a stream slave carrying one block per item: four luma samples and
//   the shared u and v samples. out_* is a stream master carrying one item per
//   block with red, green and blue of all four pixels.
//   an item taken on in_* is held in an input register; the converted pixels
//   are loaded into the output register once it is empty or being drained.
//   throughput is one block per cycle while out_tready is high: both registers
//   advance together, and the chroma lookups, adds and clamps sit in the single
//   logic level between them. when out_tready is low the output register holds
//   its item; the input register still takes one more item if it is empty, then
//   in_tready drops until the output drains.
//   reset (rst_n low, synchronous) empties both registers; nothing is retained.
module yuv420_quad_to_rgb (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right, chroma_u, chroma_v
  input  logic [yqrgb_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // per pixel red, green, blue; pixels top_left, top_right, bottom_left, bottom_right
  output logic [yqrgb_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import yqrgb_pkg::*;

  logic                   s1_valid_r;
  logic [IN_DATA_W-1:0]   s1_data_r;
  logic                   out_valid_r;
  logic [OUT_DATA_W-1:0]  out_data_r;
  logic [OUT_DATA_W-1:0]  out_data_nxt;
  logic                   s2_ready;
  logic                   s1_ready;

  sample_t chroma_u;
  sample_t chroma_v;
  term_t   rv;
  term_t   gv;
  term_t   gu;
  term_t   bu;
  sum_t    green_term;

  // flow control: each register loads when it is empty or its consumer takes
  assign s2_ready  = !out_valid_r || out_tready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign in_tready = s1_ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_tvalid) begin
      s1_data_r <= in_tdata;
    end
  end

  // chroma term lookups
  assign chroma_u   = s1_data_r[4*SAMPLE_W +: SAMPLE_W];
  assign chroma_v   = s1_data_r[5*SAMPLE_W +: SAMPLE_W];
  assign rv         = RV_TABLE[chroma_v];
  assign gv         = GV_TABLE[chroma_v];
  assign gu         = GU_TABLE[chroma_u];
  assign bu         = BU_TABLE[chroma_u];
  assign green_term = sum_t'(gv) + sum_t'(gu);

  // per pixel add and clamp
  for (genvar p = 0; p < NUM_PIX; p++) begin : g_pix
    sum_t luma;
    assign luma = sum_t'({1'b0, s1_data_r[p*SAMPLE_W +: SAMPLE_W]});
    assign out_data_nxt[(p*NUM_CHAN+0)*SAMPLE_W +: SAMPLE_W] = clamp8(luma + sum_t'(rv));
    assign out_data_nxt[(p*NUM_CHAN+1)*SAMPLE_W +: SAMPLE_W] = clamp8(luma + green_term);
    assign out_data_nxt[(p*NUM_CHAN+2)*SAMPLE_W +: SAMPLE_W] = clamp8(luma + sum_t'(bu));
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef ASSERT_OFF
  // an accepted item lands in the input register
  a_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> s1_valid_r)
    else $error("accepted item missing from input register");

  // a stalled input register keeps its item
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_ready) |=> (s1_valid_r && $stable(s1_data_r)))
    else $error("input register item lost during stall");

  // an item moving out of the input register shows up as a result
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_ready) |=> out_tvalid)
    else $error("item dropped between input and output register");

  // an empty input register never refuses an item
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("in_tready low with empty input register");
`endif

endmodule
